/* rtl/core/hcpd_pkg.sv */
// shared types, codes and constants of the hid command packet deframer
`timescale 1ns / 1ps
`default_nettype none
package hcpd_pkg;

   // default sizes
   localparam int MAX_PACKET_DEF = 512;
   localparam int CLIENTS_DEF    = 16;

   // result kinds
   localparam logic [1:0] KIND_MOUSE = 2'd0;
   localparam logic [1:0] KIND_KEYS  = 2'd1;
   localparam logic [1:0] KIND_ACK   = 2'd2;
   localparam logic [1:0] KIND_HELLO = 2'd3;

   // packet type codes
   localparam logic [7:0] TYPE_ORDERED   = 8'd100;
   localparam logic [7:0] TYPE_ALWAYS    = 8'd50;
   localparam logic [7:0] TYPE_UNMOUNTED = 8'd44;

   // greeting text and mouse marker byte
   localparam logic [7:0] GREET_0   = 8'h48;
   localparam logic [7:0] GREET_1   = 8'h69;
   localparam logic [7:0] GREET_2   = 8'h21;
   localparam logic [7:0] BYTE_FULL = 8'hFF;

   // packet layout
   localparam int GREET_LEN  = 3;
   localparam int MIN_LEN    = 10;
   localparam int CHUNK_BASE = 9;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [31:0] client_address;
      logic        usb_mounted;
      logic [7:0]  queue_space;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [63:0] report_bytes;
      logic [63:0] ack_sequence;
      logic [7:0]  ack_type;
      logic [7:0]  ack_space;
      logic [7:0]  ack_checksum;
      logic        last_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SEQ_RD,
      ST_SEQ_CMP,
      ST_STORE,
      ST_CHUNK,
      ST_ACK,
      ST_HELLO
   } state_type;

endpackage
`default_nettype wire

/* rtl/core/hid_command_packet_deframer.sv */
// hid command packet deframer: buffers packet bytes and decodes each finished packet
//
//  channel   ports                      handshake
//  request   start, busy, req_item      taken when start high and busy low
//  result    rsp_strobe, rsp_item       one cycle per result, no back pressure
//
// a packet byte that is not the last one leaves the block idle, ready for the next byte.
// the last byte starts decoding: classification, a search of the client table entry
// by entry (type 100 and greeting), and chunks read byte by byte from the packet ram.
// busy stays high while decoding; results come one at a time from an output register.
// synchronous reset clears the client valid bits, the byte count and the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module hid_command_packet_deframer
   import hcpd_pkg::*;
#(
   parameter int MAX_PACKET = MAX_PACKET_DEF,
   parameter int CLIENTS    = CLIENTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int CNT_W = $clog2(MAX_PACKET + 1);
   localparam int PA_W  = $clog2(MAX_PACKET);
   localparam int CI_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         kept_ff, kept_in;
   logic [7:0]         type_ff, type_in;
   logic [63:0]        seq_ff, seq_in;
   logic [31:0]        addr_ff, addr_in;
   logic               mounted_ff, mounted_in;
   logic [7:0]         space_ff, space_in;
   logic [CI_W-1:0]    idx_ff, idx_in;
   logic [CI_W-1:0]    hit_ff, hit_in;
   logic               found_ff, found_in;
   logic [CI_W-1:0]    free_ff, free_in;
   logic               free_ok_ff, free_ok_in;
   logic               hello_ff, hello_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [CNT_W-1:0]   end_ff, end_in;
   logic               pend_ff, pend_in;
   logic [2:0]         bc_ff, bc_in;
   logic [55:0]        chunk_ff, chunk_in;
   logic [CLIENTS-1:0] valid_ff, valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic               accept, keep, cks_ok, greet_ok;
   logic [CNT_W-1:0]   content;
   logic [7:0]         pkt_rdata;
   logic [31:0]        cli_addr_rdata;
   logic [63:0]        cli_seq_rdata;
   logic [63:0]        stored_seq;
   logic               cli_we, cli_seq_we;
   logic [CI_W-1:0]    cli_waddr;
   logic [63:0]        cli_wseq;
   logic [7:0]         ack_sum;

   assign accept = start && !busy;
   assign keep   = count_ff < CNT_W'(MAX_PACKET);
   assign cks_ok = (8'(sum_ff - kept_ff)) == kept_ff;
   assign greet_ok = (type_ff == GREET_0) && (seq_ff[15:8] == GREET_1)
                     && (seq_ff[7:0] == GREET_2);
   assign content = count_ff - CNT_W'(MIN_LEN);
   assign stored_seq = found_ff ? cli_seq_rdata : 64'd0;

   // ack checksum over sequence bytes, type and space
   always_comb begin
      ack_sum = type_ff + space_ff;
      for (int i = 0; i < 8; i++) begin
         ack_sum = ack_sum + seq_ff[8*i +: 8];
      end
   end

   // packet buffer
   hcpd_ram #(.WIDTH(8), .DEPTH(MAX_PACKET)) u_pkt_ram (
      .clock (clock),
      .we    (accept && keep),
      .waddr (count_ff[PA_W-1:0]),
      .wdata (req_item.data_byte),
      .raddr (issue_ff[PA_W-1:0]),
      .rdata (pkt_rdata)
   );

   // client address table
   hcpd_ram #(.WIDTH(32), .DEPTH(CLIENTS)) u_addr_ram (
      .clock (clock),
      .we    (cli_we),
      .waddr (cli_waddr),
      .wdata (addr_ff),
      .raddr (idx_ff),
      .rdata (cli_addr_rdata)
   );

   // client sequence table
   hcpd_ram #(.WIDTH(64), .DEPTH(CLIENTS)) u_seq_ram (
      .clock (clock),
      .we    (cli_seq_we),
      .waddr (cli_waddr),
      .wdata (cli_wseq),
      .raddr (hit_ff),
      .rdata (cli_seq_rdata)
   );

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         sum_ff    <= '0;
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         valid_ff  <= valid_in;
         strobe_ff <= strobe_in;
         pend_ff   <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kept_ff    <= kept_in;
      type_ff    <= type_in;
      seq_ff     <= seq_in;
      addr_ff    <= addr_in;
      mounted_ff <= mounted_in;
      space_ff   <= space_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      found_ff   <= found_in;
      free_ff    <= free_in;
      free_ok_ff <= free_ok_in;
      hello_ff   <= hello_in;
      issue_ff   <= issue_in;
      end_ff     <= end_in;
      bc_ff      <= bc_in;
      chunk_ff   <= chunk_in;
      rsp_ff     <= rsp_in;
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      sum_in     = sum_ff;
      kept_in    = kept_ff;
      type_in    = type_ff;
      seq_in     = seq_ff;
      addr_in    = addr_ff;
      mounted_in = mounted_ff;
      space_in   = space_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      found_in   = found_ff;
      free_in    = free_ff;
      free_ok_in = free_ok_ff;
      hello_in   = hello_ff;
      issue_in   = issue_ff;
      end_in     = end_ff;
      pend_in    = 1'b0;
      bc_in      = bc_ff;
      chunk_in   = chunk_ff;
      valid_in   = valid_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      cli_we     = 1'b0;
      cli_seq_we = 1'b0;
      cli_waddr  = found_ff ? hit_ff : free_ff;
      cli_wseq   = hello_ff ? 64'd0 : seq_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // capture header bytes and keep the running sum
               if (keep) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_ff + req_item.data_byte;
                  kept_in  = req_item.data_byte;
                  if (count_ff == '0) begin
                     type_in = req_item.data_byte;
                  end else if (count_ff <= CNT_W'(8)) begin
                     seq_in = {seq_ff[55:0], req_item.data_byte};
                  end
               end
               addr_in    = req_item.client_address;
               mounted_in = req_item.usb_mounted;
               space_in   = req_item.queue_space;
               if (req_item.last_byte) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            // classify the finished packet
            count_in   = '0;
            sum_in     = '0;
            idx_in     = '0;
            found_in   = 1'b0;
            free_ok_in = 1'b0;
            issue_in   = CNT_W'(CHUNK_BASE);
            end_in     = CNT_W'(CHUNK_BASE) + (content & ~CNT_W'(7));
            bc_in      = '0;
            hello_in   = 1'b0;
            if (!mounted_ff) begin
               seq_in   = '0;
               type_in  = TYPE_UNMOUNTED;
               state_in = ST_ACK;
            end else if (count_ff == CNT_W'(GREET_LEN)) begin
               hello_in = 1'b1;
               state_in = greet_ok ? ST_SRCH_RD : ST_IDLE;
            end else if (count_ff < CNT_W'(MIN_LEN) || !cks_ok) begin
               state_in = ST_IDLE;
            end else if (count_ff > CNT_W'(MIN_LEN) && type_ff == TYPE_ORDERED) begin
               state_in = ST_SRCH_RD;
            end else if (count_ff > CNT_W'(MIN_LEN) && type_ff == TYPE_ALWAYS) begin
               state_in = ST_CHUNK;
            end else begin
               state_in = ST_ACK;
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            // one table entry per pass
            if (valid_ff[idx_ff] && cli_addr_rdata == addr_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
            end else if (!valid_ff[idx_ff] && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = idx_ff;
            end
            if ((valid_ff[idx_ff] && cli_addr_rdata == addr_ff)
                || idx_ff == CI_W'(CLIENTS - 1)) begin
               if (hello_ff) begin
                  state_in = ST_STORE;
               end else if (valid_ff[idx_ff] && cli_addr_rdata == addr_ff) begin
                  state_in = ST_SEQ_RD;
               end else begin
                  state_in = ST_SEQ_CMP;
               end
            end else begin
               idx_in   = idx_ff + CI_W'(1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_SEQ_RD: begin
            state_in = ST_SEQ_CMP;
         end
         ST_SEQ_CMP: begin
            state_in = (stored_seq < seq_ff) ? ST_STORE : ST_ACK;
         end
         ST_STORE: begin
            // update existing entry or take the free one
            if (found_ff) begin
               cli_seq_we = 1'b1;
            end else if (free_ok_ff) begin
               cli_we          = 1'b1;
               cli_seq_we      = 1'b1;
               valid_in[free_ff] = 1'b1;
            end
            state_in = hello_ff ? ST_HELLO : ST_CHUNK;
         end
         ST_CHUNK: begin
            // stream chunk bytes from the packet ram
            if (issue_ff != end_ff) begin
               issue_in = issue_ff + CNT_W'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               chunk_in = {chunk_ff[47:0], pkt_rdata};
               bc_in    = bc_ff + 3'd1;
               if (bc_ff == 3'd7) begin
                  rsp_in = '0;
                  rsp_in.result_kind = (chunk_ff[7:0] == BYTE_FULL && pkt_rdata == BYTE_FULL)
                                       ? KIND_MOUSE : KIND_KEYS;
                  rsp_in.report_bytes = {chunk_ff, pkt_rdata};
                  strobe_in = 1'b1;
               end
            end else if (issue_ff == end_ff) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            rsp_in              = '0;
            rsp_in.result_kind  = KIND_ACK;
            rsp_in.ack_sequence = seq_ff;
            rsp_in.ack_type     = type_ff;
            rsp_in.ack_space    = space_ff;
            rsp_in.ack_checksum = ack_sum;
            rsp_in.last_result  = 1'b1;
            strobe_in           = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_HELLO: begin
            rsp_in             = '0;
            rsp_in.result_kind = KIND_HELLO;
            rsp_in.last_result = 1'b1;
            strobe_in          = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   // a result always comes from a decoding cycle
   a_strobe_from_decode: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff != ST_IDLE))
      else $error("result strobe without decoding");

   // the last result of a packet leaves the block ready
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.last_result) |-> !busy)
      else $error("busy after last result");

   // a final byte always starts decoding
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.last_byte) |=> (state_ff == ST_EVAL))
      else $error("final byte did not start decoding");

   // chunk reads stay inside the chunk area
   a_chunk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHUNK) |-> (issue_ff <= end_ff))
      else $error("chunk read past end");

endmodule
`default_nettype wire

/* rtl/core/hcpd_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hcpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

/* sim/tb_hid_command_packet_deframer.sv */
// self-checking testbench of the hid command packet deframer
`timescale 1ns / 1ps
`default_nettype none
module tb_hid_command_packet_deframer;
   import hcpd_pkg::*;

   localparam int STORE_DEPTH = MAX_PACKET_DEF;
   localparam int TABLE_DEPTH = CLIENTS_DEF;
   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 600;
   localparam int REQ_W       = $bits(req_type);

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   hid_command_packet_deframer dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // model state of the deframer
   logic [7:0]  pkt_store [STORE_DEPTH];
   int          pkt_len;
   logic [7:0]  pkt_sum;
   logic [31:0] cl_addr [TABLE_DEPTH];
   logic [63:0] cl_seq [TABLE_DEPTH];
   logic        cl_valid [TABLE_DEPTH];

   rsp_type expected_results [$];
   logic    fixed_on;
   rsp_type fixed_rsp;
   int      errors, checked, packets, requests;
   int      kind_seen [4];
   int      idle_cycles;

   // bytes of the packet being sent
   logic [7:0] pkt [$];

   function automatic int find_client(logic [31:0] addr);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (cl_valid[i] && cl_addr[i] == addr) return i;
      return -1;
   endfunction

   function automatic void store_client(logic [31:0] addr, logic [63:0] seq);
      int i;
      i = find_client(addr);
      if (i < 0) begin
         for (i = 0; i < TABLE_DEPTH; i++)
            if (!cl_valid[i]) break;
         if (i >= TABLE_DEPTH) return;
         cl_valid[i] = 1'b1;
         cl_addr[i]  = addr;
      end
      cl_seq[i] = seq;
   endfunction

   function automatic void push_ack(logic [63:0] seq, logic [7:0] ptype, logic [7:0] space);
      rsp_type r;
      logic [7:0] cks;
      cks = ptype + space;
      for (int i = 0; i < 8; i++) cks += seq[8*i +: 8];
      r = '0;
      r.result_kind  = KIND_ACK;
      r.ack_sequence = seq;
      r.ack_type     = ptype;
      r.ack_space    = space;
      r.ack_checksum = cks;
      r.last_result  = 1'b1;
      expected_results.push_back(r);
   endfunction

   function automatic void push_chunks(int len);
      rsp_type r;
      int off;
      for (off = 0; off + 8 <= len - 10; off += 8) begin
         r = '0;
         for (int i = 0; i < 8; i++)
            r.report_bytes = {r.report_bytes[55:0], pkt_store[CHUNK_BASE + off + i]};
         r.result_kind = (pkt_store[CHUNK_BASE + off + 6] == BYTE_FULL &&
                          pkt_store[CHUNK_BASE + off + 7] == BYTE_FULL) ? KIND_MOUSE : KIND_KEYS;
         expected_results.push_back(r);
      end
   endfunction

   // decode of a finished packet
   function automatic void decode_packet(req_type q);
      rsp_type r;
      logic [7:0]  ptype;
      logic [63:0] seq, stored;
      int c;
      if (!q.usb_mounted) begin
         push_ack('0, TYPE_UNMOUNTED, q.queue_space);
         return;
      end
      if (pkt_len == GREET_LEN) begin
         if (pkt_store[0] == GREET_0 && pkt_store[1] == GREET_1 && pkt_store[2] == GREET_2) begin
            store_client(q.client_address, '0);
            r = '0;
            r.result_kind = KIND_HELLO;
            r.last_result = 1'b1;
            expected_results.push_back(r);
         end
         return;
      end
      if (pkt_len < MIN_LEN) return;
      if (8'(pkt_sum - pkt_store[pkt_len-1]) != pkt_store[pkt_len-1]) return;
      ptype = pkt_store[0];
      seq = '0;
      for (int i = 1; i <= 8; i++) seq = {seq[55:0], pkt_store[i]};
      if (pkt_len > MIN_LEN) begin
         if (ptype == TYPE_ORDERED) begin
            c = find_client(q.client_address);
            stored = (c >= 0) ? cl_seq[c] : '0;
            if (stored < seq) begin
               push_chunks(pkt_len);
               store_client(q.client_address, seq);
            end
         end else if (ptype == TYPE_ALWAYS) begin
            push_chunks(pkt_len);
         end
      end
      push_ack(seq, ptype, q.queue_space);
   endfunction

   // one accepted request
   function automatic void take_request(req_type q);
      int before_n;
      requests++;
      if (pkt_len < STORE_DEPTH) begin
         pkt_store[pkt_len] = q.data_byte;
         pkt_len++;
         pkt_sum += q.data_byte;
      end
      if (!q.last_byte) return;
      before_n = expected_results.size();
      decode_packet(q);
      if (fixed_on) begin
         while (expected_results.size() > before_n) void'(expected_results.pop_back());
         expected_results.push_back(fixed_rsp);
      end
      packets++;
      pkt_len = 0;
      pkt_sum = '0;
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // acceptance, result checking and watchdog
   always @(posedge clock) begin
      rsp_type e;
      logic    active;
      if (!reset) begin
         active = 1'b0;
         if (start && !busy) begin
            take_request(req_item);
            active = 1'b1;
         end
         if (rsp_strobe) begin
            active = 1'b1;
            if (expected_results.size() == 0) begin
               $error("unexpected result, kind %0d", rsp_item.result_kind);
               errors++;
            end else begin
               e = expected_results.pop_front();
               checked++;
               kind_seen[e.result_kind]++;
               check_field("result_kind", 64'(e.result_kind), 64'(rsp_item.result_kind));
               check_field("report_bytes", e.report_bytes, rsp_item.report_bytes);
               check_field("ack_sequence", e.ack_sequence, rsp_item.ack_sequence);
               check_field("ack_type", 64'(e.ack_type), 64'(rsp_item.ack_type));
               check_field("ack_space", 64'(e.ack_space), 64'(rsp_item.ack_space));
               check_field("ack_checksum", 64'(e.ack_checksum), 64'(rsp_item.ack_checksum));
               check_field("last_result", 64'(e.last_result), 64'(rsp_item.last_result));
            end
         end
         idle_cycles <= active ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // sends one request and holds it until accepted
   task automatic send_byte(req_type q, int gap);
      @(negedge clock);
      start    = 1'b1;
      req_item = q;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         req_item = REQ_W'({$urandom, $urandom});
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // sends the bytes in pkt as one packet
   task automatic send_packet(logic [31:0] addr, logic mounted, logic [7:0] space,
                              logic no_gaps);
      req_type q;
      for (int i = 0; i < pkt.size(); i++) begin
         q = REQ_W'({$urandom, $urandom});
         q.data_byte = pkt[i];
         q.last_byte = (i == pkt.size() - 1);
         if (q.last_byte) begin
            q.client_address = addr;
            q.usb_mounted    = mounted;
            q.queue_space    = space;
         end
         send_byte(q, no_gaps ? 0 : pick_gap());
      end
   endtask

   function automatic void fix_checksum();
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < pkt.size() - 1; i++) s += pkt[i];
      pkt[pkt.size()-1] = s;
   endfunction

   // builds type, sequence, chunks, trailing bytes and a checksum slot
   function automatic void build_frame(logic [7:0] ptype, logic [63:0] seq, int chunks,
                                       int tail);
      pkt.delete();
      pkt.push_back(ptype);
      for (int i = 7; i >= 0; i--) pkt.push_back(seq[8*i +: 8]);
      for (int c = 0; c < chunks; c++) begin
         for (int i = 0; i < 8; i++) pkt.push_back(8'($urandom));
         if ($urandom_range(1)) begin
            pkt[pkt.size()-1] = BYTE_FULL;
            pkt[pkt.size()-2] = BYTE_FULL;
         end else if ($urandom_range(3) == 0) begin
            pkt[pkt.size()-2] = BYTE_FULL;
         end
      end
      for (int i = 0; i < tail; i++) pkt.push_back(8'($urandom));
      pkt.push_back(8'h00);
      fix_checksum();
   endfunction

   // directed packets, bytes right aligned with the first byte leftmost
   typedef struct {
      int           len;
      logic [191:0] bytes;
      logic         fix_cks;
      logic [31:0]  addr;
      logic         mounted;
      logic [7:0]   space;
      logic         has_fixed;
      rsp_type      fixed;
   } row_type;

   row_type rows [$];

   function automatic void add_row(int len, logic [191:0] b, logic fix, logic [31:0] addr,
                                   logic mounted, logic [7:0] space, logic has_fixed,
                                   rsp_type fixed);
      row_type r;
      r.len = len; r.bytes = b; r.fix_cks = fix; r.addr = addr;
      r.mounted = mounted; r.space = space; r.has_fixed = has_fixed; r.fixed = fixed;
      rows.push_back(r);
   endfunction

   initial begin
      logic [31:0] pool [20];
      logic [31:0] addr;
      logic [63:0] seq;
      logic [7:0]  ptype;
      rsp_type     none;
      int          r, rand_bytes;

      none = '0;
      start = 1'b0;
      req_item = '0;
      fixed_on = 1'b0;
      fixed_rsp = '0;
      errors = 0; checked = 0; packets = 0; requests = 0; idle_cycles = 0;
      pkt_len = 0; pkt_sum = '0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (cl_valid[i]) cl_valid[i] = 1'b0;
      foreach (pool[i]) pool[i] = $urandom;

      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      add_row(1, 192'hFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 8'hFF, 1'b1,
              {KIND_ACK, 64'd0, 64'd0, TYPE_UNMOUNTED, 8'hFF, 8'd43, 1'b1});
      add_row(3, 192'h486921, 1'b0, 32'h0000_0000, 1'b1, 8'h00, 1'b1,
              {KIND_HELLO, 64'd0, 64'd0, 8'd0, 8'd0, 8'd0, 1'b1});
      add_row(3, 192'h486922, 1'b0, 32'h0A00_0001, 1'b1, 8'h10, 1'b0, none);
      add_row(5, 192'h0102030405, 1'b0, 32'h0A00_0001, 1'b1, 8'h10, 1'b0, none);
      add_row(10, 192'h07_0000000000000001_00, 1'b1, 32'h0A00_0001, 1'b1, 8'h00, 1'b0, none);
      add_row(21, 192'h32_0000000000000002_0102030405FFFFFF_AABBCC_00, 1'b1,
              32'h0A00_0001, 1'b1, 8'h80, 1'b0, none);
      add_row(18, 192'h64_0000000000000005_0004000000000000_00, 1'b1,
              32'h0000_0000, 1'b1, 8'h01, 1'b0, none);
      add_row(18, 192'h64_0000000000000005_0005000000000000_00, 1'b1,
              32'h0000_0000, 1'b1, 8'h02, 1'b0, none);
      add_row(18, 192'h64_0000000000000004_0006000000000000_00, 1'b1,
              32'h0000_0000, 1'b1, 8'h03, 1'b0, none);
      add_row(18, 192'h32_0000000000000009_0007000000000000_00, 1'b0,
              32'h0000_0000, 1'b1, 8'h04, 1'b0, none);
      add_row(18, 192'h64_FFFFFFFFFFFFFFFF_FFFFFFFFFFFFFFFF_00, 1'b1,
              32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b0, none);
      add_row(10, 192'h00_0000000000000000_00, 1'b0, 32'h5555_AAAA, 1'b1, 8'h00, 1'b0, none);
      foreach (rows[k]) begin
         pkt.delete();
         for (int i = 0; i < rows[k].len; i++)
            pkt.push_back(rows[k].bytes[8*(rows[k].len-1-i) +: 8]);
         if (rows[k].fix_cks) fix_checksum();
         @(negedge clock);
         fixed_on  = rows[k].has_fixed;
         fixed_rsp = rows[k].fixed;
         send_packet(rows[k].addr, rows[k].mounted, rows[k].space, k % 3 == 0);
         @(negedge clock);
         fixed_on = 1'b0;
      end

      // random packets, mostly well formed
      rand_bytes = 0;
      for (int p = 0; rand_bytes < 180 || p < 8; p++) begin
         if (p == 3) begin
            // overlong packet: bytes past the buffer are dropped, the last kept byte is the checksum
            build_frame(TYPE_ALWAYS, {$urandom, $urandom}, 62, 0);
            for (int i = 0; i < 8; i++) pkt.push_back(8'($urandom));
            send_packet(pool[0], 1'b1, 8'($urandom), 1'b0);
            continue;
         end
         if (p == 5) begin
            // register more clients than the table holds
            for (int c = 0; c < 20; c++) begin
               pkt = {GREET_0, GREET_1, GREET_2};
               send_packet(pool[c], 1'b1, 8'($urandom), (c % 2) != 0);
            end
            continue;
         end
         addr = ($urandom_range(9) < 7) ? pool[$urandom_range(19)] : $urandom;
         r = $urandom_range(99);
         if (r < 45) begin
            ptype = (r < 28) ? TYPE_ORDERED : TYPE_ALWAYS;
            seq = ($urandom_range(2) != 0) ? 64'($urandom_range(20)) : {$urandom, $urandom};
            build_frame(ptype, seq, $urandom_range(4), $urandom_range(7));
         end else if (r < 55) begin
            pkt = {GREET_0, GREET_1, GREET_2};
         end else if (r < 65) begin
            build_frame(8'($urandom), {$urandom, $urandom}, $urandom_range(2), 0);
            send_packet(addr, 1'b0, 8'($urandom), $urandom_range(1) != 0);
            rand_bytes += pkt.size();
            continue;
         end else if (r < 75) begin
            build_frame(8'($urandom), {$urandom, $urandom}, $urandom_range(3),
                        $urandom_range(7));
         end else if (r < 85) begin
            build_frame(($urandom_range(1) != 0) ? TYPE_ALWAYS : TYPE_ORDERED,
                        {$urandom, $urandom}, $urandom_range(3), 0);
            pkt[pkt.size()-1] ^= 8'($urandom_range(255, 1));
         end else if (r < 95) begin
            pkt.delete();
            repeat ($urandom_range(9, 1)) pkt.push_back(8'($urandom));
         end else begin
            pkt = {GREET_0, GREET_1, GREET_2};
            pkt[$urandom_range(2)] ^= 8'(1 << $urandom_range(7));
         end
         send_packet(addr, 1'b1, 8'($urandom), $urandom_range(3) == 0);
         rand_bytes += pkt.size();
      end

      @(negedge clock);
      start = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d packets in %0d requests, %0d results checked", packets, requests, checked);
      $display("results by kind: mouse %0d, keyboard %0d, ack %0d, greeting %0d",
               kind_seen[KIND_MOUSE], kind_seen[KIND_KEYS], kind_seen[KIND_ACK],
               kind_seen[KIND_HELLO]);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
